FILE: design/sts_pkg.sv
package sts_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;

   // fixed field widths of the words on the ports
   localparam int MODE_W  = 2;
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;
   localparam int CSR_W   = 11;
   localparam int FIRST_W = 11;
   localparam int LAST_W  = 10;

endpackage

FILE: design/sts_mem.sv
module sts_mem
   import sts_pkg::*;
#(
   parameter int DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int IDX_W = INDEX_W
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic [IDX_W-1:0]   rd_a_addr,
   input  logic [IDX_W-1:0]   rd_b_addr,
   output logic [VALUE_W-1:0] rd_a_data,
   output logic [VALUE_W-1:0] rd_b_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_a_ff;
   logic [VALUE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

FILE: design/sts_ctrl.sv
module sts_ctrl
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int IDX_W       = INDEX_W,
   parameter int CNT_W       = CSR_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [CNT_W-1:0]          live_count,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic [INDEX_W-1:0]        req_entry_index,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic [FIRST_W-1:0]        rsp_first_pos,
   output logic [LAST_W-1:0]         rsp_last_pos,
   output logic                      mem_wr_en,
   output logic [IDX_W-1:0]          mem_wr_addr,
   output logic [VALUE_W-1:0]        mem_wr_data,
   output logic [IDX_W-1:0]          mem_rd_a_addr,
   output logic [IDX_W-1:0]          mem_rd_b_addr,
   input  logic [VALUE_W-1:0]        mem_rd_a_data,
   input  logic [VALUE_W-1:0]        mem_rd_b_data
);

   localparam int POS_W = CNT_W + 1;
   typedef logic signed [POS_W-1:0] pos_type;

   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EXACT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd2;

   localparam pos_type BORDER_NONE = pos_type'(-2);
   localparam pos_type ONE         = pos_type'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [MODE_W-1:0]         mode_ff, mode_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   pos_type                   lo_ff, lo_in;
   pos_type                   hi_ff, hi_in;
   pos_type                   mid_a_ff, mid_a_in;
   pos_type                   mid_b_ff, mid_b_in;
   logic                      sel_ff, sel_in;
   logic                      phase_ff, phase_in;
   pos_type                   border_ff, border_in;
   pos_type                   left_ff, left_in;
   logic                      res_found_ff, res_found_in;
   pos_type                   res_first_ff, res_first_in;
   pos_type                   res_last_ff, res_last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [FIRST_W-1:0]        rsp_first_ff, rsp_first_in;
   logic [LAST_W-1:0]         rsp_last_ff, rsp_last_in;

   pos_type                   mid;
   pos_type                   mid_left;
   pos_type                   mid_right;
   pos_type                   start_hi;
   pos_type                   start_mid;
   logic signed [VALUE_W-1:0] probe;
   logic                      live;
   logic                      gt;
   logic                      lt;
   logic                      restart;

   // both children of the current probe are read ahead, the compare picks one
   assign mid       = sel_ff ? mid_b_ff : mid_a_ff;
   assign probe     = sel_ff ? signed'(mem_rd_b_data) : signed'(mem_rd_a_data);
   assign mid_left  = lo_ff + ((mid - ONE - lo_ff) >>> 1);
   assign mid_right = mid + ONE + ((hi_ff - mid - ONE) >>> 1);
   assign start_hi  = pos_type'(live_count) - ONE;
   assign start_mid = start_hi >>> 1;
   assign live      = (lo_ff <= hi_ff);
   assign gt        = (probe > key_ff);
   assign lt        = (probe < key_ff);
   assign restart   = (state_ff == ST_SEARCH) && !live && !phase_ff
                      && (mode_ff != MODE_EXACT) && (mode_ff != MODE_INSERT);

   assign mem_wr_addr   = IDX_W'(req_entry_index);
   assign mem_wr_data   = req_value;
   assign mem_rd_a_addr = (state_ff == ST_IDLE || restart) ? IDX_W'(start_mid)
                                                           : IDX_W'(mid_left);
   assign mem_rd_b_addr = IDX_W'(mid_right);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_a_in     = mid_a_ff;
      mid_b_in     = mid_b_ff;
      sel_in       = sel_ff;
      phase_in     = phase_ff;
      border_in    = border_ff;
      left_in      = left_ff;
      res_found_in = res_found_ff;
      res_first_in = res_first_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_first_in = rsp_first_ff;
      rsp_last_in  = rsp_last_ff;
      mem_wr_en    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_LOAD) begin
                  mem_wr_en = (32'(req_entry_index) < 32'(TABLE_DEPTH));
               end else begin
                  mode_in   = req_mode;
                  key_in    = req_value;
                  lo_in     = '0;
                  hi_in     = start_hi;
                  mid_a_in  = start_mid;
                  sel_in    = 1'b0;
                  phase_in  = 1'b0;
                  border_in = BORDER_NONE;
                  state_in  = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (live) begin
               mid_a_in = mid_left;
               mid_b_in = mid_right;
               priority if (mode_ff == MODE_EXACT || mode_ff == MODE_INSERT) begin
                  if (gt) begin
                     hi_in  = mid - ONE;
                     sel_in = 1'b0;
                  end else if (lt) begin
                     lo_in  = mid + ONE;
                     sel_in = 1'b1;
                  end else begin
                     res_found_in = 1'b1;
                     res_first_in = mid;
                     res_last_in  = '0;
                     state_in     = ST_DONE;
                  end
               end else if (!phase_ff) begin
                  // left border: move left on probe >= key
                  if (!lt) begin
                     hi_in     = mid - ONE;
                     border_in = mid - ONE;
                     sel_in    = 1'b0;
                  end else begin
                     lo_in  = mid + ONE;
                     sel_in = 1'b1;
                  end
               end else begin
                  // right border: move right on probe <= key
                  if (gt) begin
                     hi_in  = mid - ONE;
                     sel_in = 1'b0;
                  end else begin
                     lo_in     = mid + ONE;
                     border_in = mid + ONE;
                     sel_in    = 1'b1;
                  end
               end
            end else begin
               priority if (mode_ff == MODE_EXACT) begin
                  res_found_in = 1'b0;
                  res_first_in = '0;
                  res_last_in  = '0;
                  state_in     = ST_DONE;
               end else if (mode_ff == MODE_INSERT) begin
                  res_found_in = 1'b1;
                  res_first_in = hi_ff + ONE;
                  res_last_in  = '0;
                  state_in     = ST_DONE;
               end else if (!phase_ff) begin
                  left_in   = border_ff;
                  lo_in     = '0;
                  hi_in     = start_hi;
                  mid_a_in  = start_mid;
                  sel_in    = 1'b0;
                  border_in = BORDER_NONE;
                  phase_in  = 1'b1;
               end else begin
                  // compare without a difference so a full-width span cannot wrap
                  if (left_ff != BORDER_NONE && border_ff != BORDER_NONE
                      && border_ff > left_ff + ONE) begin
                     res_found_in = 1'b1;
                     res_first_in = left_ff + ONE;
                     res_last_in  = border_ff - ONE;
                  end else begin
                     res_found_in = 1'b0;
                     res_first_in = '0;
                     res_last_in  = '0;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_first_in = FIRST_W'($unsigned(res_first_ff));
               rsp_last_in  = LAST_W'($unsigned(res_last_ff));
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         key_ff       <= key_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         mid_a_ff     <= mid_a_in;
         mid_b_ff     <= mid_b_in;
         sel_ff       <= sel_in;
         phase_ff     <= phase_in;
         border_ff    <= border_in;
         left_ff      <= left_in;
         res_found_ff <= res_found_in;
         res_first_ff <= res_first_in;
         res_last_ff  <= res_last_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_found_ff <= rsp_found_in;
         rsp_first_ff <= rsp_first_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_first_pos = rsp_first_ff;
   assign rsp_last_pos  = rsp_last_ff;

endmodule

FILE: design/sorted_table_search_top.sv
// load word: written in the cycle it is taken, no result; the block stays idle, ready for the next word
// search: one probe per cycle, both possible next probes are read ahead on two ram ports
// exact/insert: one binary search over the live entries, then the result
// range: two border searches back to back, left border first, then right border
// one word in flight; a finished result waits in the output register while the next is taken
// synchronous reset clears control and the entry count; table contents are kept
module sorted_table_search_top
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic [INDEX_W-1:0]        req_entry_index,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic [FIRST_W-1:0]        rsp_first_pos,
   output logic [LAST_W-1:0]         rsp_last_pos,
   input  logic                      csr_wr_en,
   input  logic [CSR_W-1:0]          csr_wr_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [CSR_W-1:0]   csr_entries_ff;
   logic [CNT_W-1:0]   live_count;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [VALUE_W-1:0] mem_wr_data;
   logic [IDX_W-1:0]   mem_rd_a_addr;
   logic [IDX_W-1:0]   mem_rd_b_addr;
   logic [VALUE_W-1:0] mem_rd_a_data;
   logic [VALUE_W-1:0] mem_rd_b_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_entries_ff <= '0;
      end else if (csr_wr_en) begin
         csr_entries_ff <= csr_wr_data;
      end
   end

   // entry count saturates at the table depth
   assign live_count = (32'(csr_entries_ff) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                                 : CNT_W'(csr_entries_ff);

   sts_mem #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_a_addr (mem_rd_a_addr),
      .rd_b_addr (mem_rd_b_addr),
      .rd_a_data (mem_rd_a_data),
      .rd_b_data (mem_rd_b_data)
   );

   sts_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .live_count      (live_count),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_entry_index (req_entry_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_first_pos   (rsp_first_pos),
      .rsp_last_pos    (rsp_last_pos),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_a_addr   (mem_rd_a_addr),
      .mem_rd_b_addr   (mem_rd_b_addr),
      .mem_rd_a_data   (mem_rd_a_data),
      .mem_rd_b_data   (mem_rd_b_data)
   );

endmodule
